// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk with i_rst_n low as
// the disable condition.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset
`define PIEA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle
`define PIEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/piea_pkg.sv
// ----------------------------------------------------------------------------
// piea_pkg
// Types, codes and defaults for the positional insert/erase array.
// ----------------------------------------------------------------------------
package piea_pkg;

    // Parameter defaults
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Position bus width, covers capacities up to 1024
    localparam int SEL_W = 10;
    // Compare width, covers a full count plus an input count
    localparam int CMP_W = SEL_W + 1;
    // Widest element value
    localparam int WIDE_W = 64;

    // Fixed field widths of the ports
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int NUM_W  = 7;
    localparam int DATA_W = 32;
    localparam int TOT_W  = 7;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_READ       = 3'd0,
        OP_INSERT     = 3'd1,
        OP_ERASE      = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_PUSH_BACK  = 3'd4,
        OP_PUSH_FRONT = 3'd5,
        OP_POP_BACK   = 3'd6,
        OP_POP_FRONT  = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    // What every cell does with its word
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_INS  = 2'd1,
        SH_DEL  = 2'd2
    } t_shift;

    // Command broadcast along the chain
    typedef struct packed {
        t_shift           mode;
        logic [SEL_W-1:0] pos;  // insert / erase point
        logic [SEL_W-1:0] sel;  // cell driving the read tap
    } t_cmd;

endpackage

// File: rtl/piea_cell.sv
// ----------------------------------------------------------------------------
// piea_cell
// One storage slot of the chain. Takes the new value on an insert at it, its
// left neighbor on an insert before it, its right one on an erase at or before it.
// ----------------------------------------------------------------------------
module piea_cell
    import piea_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [VALUE_BITS-1:0] i_left,
    input  logic [VALUE_BITS-1:0] i_right,
    output logic [VALUE_BITS-1:0] o_data,
    output logic [VALUE_BITS-1:0] o_tap
);

    localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(INDEX);

    logic [VALUE_BITS-1:0] r_data;
    logic [VALUE_BITS-1:0] n_data;

    // Next value from the broadcast command
    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            SH_INS: begin
                if (MY_IDX == i_cmd.pos) begin
                    n_data = i_value;
                end else if (MY_IDX > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            SH_DEL: begin
                if (MY_IDX >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Only the selected cell puts its word on the read bus
    assign o_tap  = (MY_IDX == i_cmd.sel) ? r_data : '0;

endmodule

// File: rtl/piea_chain.sv
// ----------------------------------------------------------------------------
// piea_chain
// Row of storage cells with neighbor links and an OR-combined read bus.
// ----------------------------------------------------------------------------
module piea_chain
    import piea_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [VALUE_BITS-1:0] o_tap
);

    logic [VALUE_BITS-1:0] w_data [CAPACITY];
    logic [VALUE_BITS-1:0] w_tap  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_left;
        logic [VALUE_BITS-1:0] w_right;

        // Ends of the row: front cell never shifts in from the left,
        // back cell keeps its word on an erase
        if (g == 0) begin : g_front
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_back
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        piea_cell #(
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_tap   (w_tap[g])
        );
    end

    // Read bus: at most one cell is non-zero
    always_comb begin
        o_tap = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_tap = o_tap | w_tap[k];
        end
    end

endmodule

// File: rtl/positional_insert_erase_array.sv
// ----------------------------------------------------------------------------
// positional_insert_erase_array
// Fixed-capacity ordered word array held in a shifting chain of cells, with
// read, insert, erase, clear, push and pop requests and one result each.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  request  | i_in_valid / o_in_ready   | i_operation i_position i_count i_value
//  result   | o_out_valid / i_out_ready | o_read_value o_element_total
//           |                           | o_is_empty o_status
//
//  A request is decoded against the element count when it is accepted; in
//  the execute step the whole chain shifts and the result is registered. An
//  insert of n copies (n >= 2) repeats the execute step, one chain shift per copy.
//  One request is in work at a time. The result sits in an output register;
//  a stalled result holds the final step, earlier insert steps go on.
//  Synchronous active-low reset empties the array; stored words keep garbage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_insert_erase_array
    import piea_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [POS_W-1:0]  i_position,
    input  logic [NUM_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_value,
    output logic [TOT_W-1:0]  o_element_total,
    output logic              o_is_empty,
    output logic [STAT_W-1:0] o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Actions that a decoded request carries into its execute step
    typedef struct packed {
        logic do_read;
        logic do_erase;
        logic do_clear;
    } t_act;

    t_state                r_state,  n_state;
    logic [CNT_W-1:0]      r_count,  n_count;
    t_status               r_status, n_status;
    t_act                  r_act,    n_act;
    logic [NUM_W-1:0]      r_left,   n_left;
    logic [SEL_W-1:0]      r_pos,    n_pos;
    logic [VALUE_BITS-1:0] r_val,    n_val;

    logic                  r_out_valid, n_out_valid;
    logic [DATA_W-1:0]     r_out_data,  n_out_data;
    logic [TOT_W-1:0]      r_out_total, n_out_total;
    logic                  r_out_empty, n_out_empty;
    t_status               r_out_stat,  n_out_stat;

    t_status               d_status;
    t_act                  d_act;
    logic [NUM_W-1:0]      d_left;
    logic [SEL_W-1:0]      d_pos;

    logic [CMP_W-1:0]      cnt_c, pos_c, num_c, cap_c, cnt_m1, sum_c, nxt_c;
    logic [WIDE_W-1:0]     val_wide, tap_wide;
    logic [VALUE_BITS-1:0] w_tap;
    t_cmd                  w_cmd;
    logic                  accept, last, out_free, go, fire_out;

    assign accept   = i_in_valid && o_in_ready;
    assign last     = (r_left == NUM_W'(0)) || (r_left == NUM_W'(1));
    assign out_free = !r_out_valid || i_out_ready;
    assign go       = (r_state == S_EXEC) && (!last || out_free);
    assign fire_out = go && last;

    // Operands widened for range checks
    assign cnt_c    = CMP_W'(r_count);
    assign pos_c    = CMP_W'(i_position);
    assign num_c    = CMP_W'(i_count);
    assign cap_c    = CMP_W'(CAPACITY);
    assign cnt_m1   = cnt_c - CMP_W'(1);
    assign sum_c    = cnt_c + num_c;
    assign val_wide = WIDE_W'(i_value);

    // Decode a request against the current count
    always_comb begin
        d_status = STAT_OK;
        d_act    = '0;
        d_left   = '0;
        d_pos    = pos_c[SEL_W-1:0];
        case (t_op'(i_operation))
            OP_READ: begin
                if (pos_c < cnt_c) begin
                    d_act.do_read = 1'b1;
                end else begin
                    d_status = STAT_RANGE;
                end
            end
            OP_INSERT: begin
                if (pos_c > cnt_c) begin
                    d_status = STAT_RANGE;
                end else if (sum_c > cap_c) begin
                    d_status = STAT_FULL;
                end else begin
                    d_left = i_count;
                end
            end
            OP_ERASE: begin
                if (pos_c < cnt_c) begin
                    d_act.do_erase = 1'b1;
                end else begin
                    d_status = STAT_RANGE;
                end
            end
            OP_CLEAR: begin
                d_act.do_clear = 1'b1;
            end
            OP_PUSH_BACK: begin
                d_pos = cnt_c[SEL_W-1:0];
                if (cnt_c >= cap_c) begin
                    d_status = STAT_FULL;
                end else begin
                    d_left = NUM_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                d_pos = '0;
                if (cnt_c >= cap_c) begin
                    d_status = STAT_FULL;
                end else begin
                    d_left = NUM_W'(1);
                end
            end
            OP_POP_BACK: begin
                d_pos = cnt_m1[SEL_W-1:0];
                if (r_count == '0) begin
                    d_status = STAT_EMPTY;
                end else begin
                    d_act.do_read  = 1'b1;
                    d_act.do_erase = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                d_pos = '0;
                if (r_count == '0) begin
                    d_status = STAT_EMPTY;
                end else begin
                    d_act.do_read  = 1'b1;
                    d_act.do_erase = 1'b1;
                end
            end
            default: d_status = STAT_OK;
        endcase
    end

    // Chain command for the execute step
    always_comb begin
        w_cmd.mode = SH_HOLD;
        w_cmd.pos  = r_pos;
        w_cmd.sel  = r_pos;
        if (go) begin
            if (r_left != '0) begin
                w_cmd.mode = SH_INS;
            end else if (r_act.do_erase) begin
                w_cmd.mode = SH_DEL;
            end
        end
    end

    piea_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (r_val),
        .o_tap   (w_tap)
    );

    assign tap_wide = WIDE_W'(w_tap);

    // Sequencer, element count and result register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_act       = r_act;
        n_left      = r_left;
        n_pos       = r_pos;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_total = r_out_total;
        n_out_empty = r_out_empty;
        n_out_stat  = r_out_stat;
        nxt_c       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = d_status;
                    n_act    = d_act;
                    n_left   = d_left;
                    n_pos    = d_pos;
                    n_val    = val_wide[VALUE_BITS-1:0];
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go) begin
                    if (r_left != '0) begin
                        n_count = r_count + CNT_W'(1);
                        n_left  = r_left - NUM_W'(1);
                    end else if (r_act.do_erase) begin
                        n_count = r_count - CNT_W'(1);
                    end else if (r_act.do_clear) begin
                        n_count = '0;
                    end
                end
                if (fire_out) begin
                    nxt_c       = CMP_W'(n_count);
                    n_out_valid = 1'b1;
                    n_out_data  = r_act.do_read ? tap_wide[DATA_W-1:0] : '0;
                    n_out_total = nxt_c[TOT_W-1:0];
                    n_out_empty = (n_count == '0);
                    n_out_stat  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_act       <= n_act;
        r_left      <= n_left;
        r_pos       <= n_pos;
        r_val       <= n_val;
        r_out_data  <= n_out_data;
        r_out_total <= n_out_total;
        r_out_empty <= n_out_empty;
        r_out_stat  <= n_out_stat;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_out_data;
    assign o_element_total = r_out_total;
    assign o_is_empty      = r_out_empty;
    assign o_status        = r_out_stat;

    // Checks
    `PIEA_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "element count above capacity")
    `PIEA_ASSERT_NEXT(a_accept_exec, accept, r_state == S_EXEC,
        "accepted request not executed")
    `PIEA_ASSERT_NEXT(a_ins_step, go && (r_left != '0),
        r_count == $past(r_count) + CNT_W'(1), "insert step did not grow count")
    `PIEA_ASSERT_NEXT(a_refused_keep, fire_out && (r_status != STAT_OK),
        r_count == $past(r_count), "refused request changed count")

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional insert/erase array. A queue-fed
// driver offers requests on the valid/ready input channel, and a predictor
// tracks the array contents on every accepted transaction. A monitor checks
// each returned result field by field against the oldest prediction. A
// directed opening covers the edge cases: empty, full, out-of-range
// positions, zero-count inserts and maximum-size inserts. Random phases
// then run with and without idle cycles on either side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import piea_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int PHASE_ITEMS = 275;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef struct {
        t_op               op;
        logic [POS_W-1:0]  pos;
        logic [NUM_W-1:0]  cnt;
        logic [DATA_W-1:0] val;
    } t_request;

    typedef struct {
        logic [DATA_W-1:0] read_value;
        logic [TOT_W-1:0]  element_total;
        logic              is_empty;
        t_status           status;
    } t_result;

    // DUT connections, all inputs known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_operation = '0;
    logic [POS_W-1:0]  i_position = '0;
    logic [NUM_W-1:0]  i_count = '0;
    logic [DATA_W-1:0] i_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_read_value;
    logic [TOT_W-1:0]  o_element_total;
    logic              o_is_empty;
    logic [STAT_W-1:0] o_status;

    // Bench state
    t_request          pending_requests[$];
    t_result           expected_results[$];
    t_request          offered;
    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;
    int                mismatches = 0;

    // Predicted array contents
    logic [DATA_W-1:0] words[CAP];
    int                word_count = 0;

    positional_insert_erase_array u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_count         (i_count),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_value    (o_read_value),
        .o_element_total (o_element_total),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Insert cnt copies at pos, shifting the tail back; range check first
    function automatic t_status insert_copies(input int pos, input int cnt,
                                              input logic [DATA_W-1:0] val);
        if (pos > word_count)
            return STAT_RANGE;
        if (word_count + cnt > CAP)
            return STAT_FULL;
        for (int i = word_count + cnt - 1; i >= pos + cnt; i--)
            words[i] = words[i - cnt];
        for (int i = 0; i < cnt; i++)
            words[pos + i] = val;
        word_count += cnt;
        return STAT_OK;
    endfunction

    // Remove the word at pos, shifting the tail forward
    function automatic void remove_at(input int pos);
        for (int i = pos; i + 1 < word_count; i++)
            words[i] = words[i + 1];
        word_count--;
    endfunction

    // Apply one request to the predicted array and form its result
    function automatic t_result apply_request(input t_request r);
        t_result res;
        res.read_value = '0;
        res.status = STAT_OK;
        case (r.op)
            OP_READ: begin
                if (r.pos < word_count)
                    res.read_value = words[r.pos];
                else
                    res.status = STAT_RANGE;
            end
            OP_INSERT: res.status = insert_copies(r.pos, r.cnt, r.val);
            OP_ERASE: begin
                if (r.pos < word_count)
                    remove_at(r.pos);
                else
                    res.status = STAT_RANGE;
            end
            OP_CLEAR: word_count = 0;
            OP_PUSH_BACK: res.status = insert_copies(word_count, 1, r.val);
            OP_PUSH_FRONT: res.status = insert_copies(0, 1, r.val);
            OP_POP_BACK: begin
                if (word_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.read_value = words[word_count - 1];
                    remove_at(word_count - 1);
                end
            end
            default: begin
                if (word_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.read_value = words[0];
                    remove_at(0);
                end
            end
        endcase
        res.element_total = word_count[TOT_W-1:0];
        res.is_empty = (word_count == 0);
        return res;
    endfunction

    // Request driver: predict on each accepted transaction, then offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_results.insert(expected_results.size(), apply_request(offered));
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    offered = pending_requests[0];
                    pending_requests.delete(0);
                    i_in_valid  <= 1'b1;
                    i_operation <= offered.op;
                    i_position  <= offered.pos;
                    i_count     <= offered.cnt;
                    i_value     <= offered.val;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (o_read_value !== want.read_value) begin
                    $error("read_value expected %0h got %0h", want.read_value, o_read_value);
                    mismatches++;
                end
                if (o_element_total !== want.element_total) begin
                    $error("element_total expected %0d got %0d",
                           want.element_total, o_element_total);
                    mismatches++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty expected %0b got %0b", want.is_empty, o_is_empty);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_request(input t_op op, input int pos, input int cnt,
                                 input logic [DATA_W-1:0] val);
        t_request r;
        r.op  = op;
        r.pos = pos[POS_W-1:0];
        r.cnt = cnt[NUM_W-1:0];
        r.val = val;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // Wait until every queued request has been sent and has returned its result
    task automatic drain();
        while (pending_requests.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        int sender_pct[4];
        int receiver_pct[4];
        int est_total;
        int pick;
        int pos;
        int cnt;
        t_op op;

        sender_pct   = '{0, 66, 0, 20};
        receiver_pct = '{0, 0, 66, 20};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty array refusals and a zero-count insert
        queue_request(OP_POP_BACK, 0, 0, 32'h0);
        queue_request(OP_POP_FRONT, 0, 0, 32'h0);
        queue_request(OP_ERASE, 0, 0, 32'h0);
        queue_request(OP_READ, 0, 0, 32'h0);
        queue_request(OP_INSERT, 1, 1, 32'h1);
        queue_request(OP_INSERT, 0, 0, 32'h2);
        // Fill to capacity in one insert, then overflow attempts and end-of-array reads and erase
        queue_request(OP_INSERT, 0, CAP, ALL_ONES);
        queue_request(OP_PUSH_BACK, 0, 0, 32'h1234_5678);
        queue_request(OP_PUSH_FRONT, 0, 0, 32'h8765_4321);
        queue_request(OP_INSERT, CAP, 0, 32'h3);
        queue_request(OP_INSERT, CAP, CAP, 32'h4);
        queue_request(OP_READ, CAP - 1, 0, 32'h0);
        queue_request(OP_READ, CAP, 0, 32'h0);
        queue_request(OP_ERASE, CAP - 1, 0, 32'h0);
        // Position beyond the end wins over overflow
        queue_request(OP_INSERT, CAP, CAP, 32'h5);
        queue_request(OP_CLEAR, 0, 0, 32'h0);
        // Small mixed sequence
        queue_request(OP_PUSH_BACK, 0, 0, 32'h0);
        queue_request(OP_PUSH_FRONT, 0, 0, ALL_ONES);
        queue_request(OP_PUSH_BACK, 0, 0, 32'hA5A5_A5A5);
        queue_request(OP_INSERT, 1, 3, 32'h5A5A_5A5A);
        queue_request(OP_READ, 4, 0, 32'h0);
        queue_request(OP_ERASE, 0, 0, 32'h0);
        queue_request(OP_POP_BACK, 0, 0, 32'h0);
        queue_request(OP_POP_FRONT, 0, 0, 32'h0);
        queue_request(OP_CLEAR, 0, 0, 32'h0);
        drain();

        // Random phases; est_total tracks the size only to aim positions
        est_total = 0;
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = sender_pct[ph];
            receiver_stall_pct = receiver_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 20)
                    op = OP_READ;
                else if (pick < 40)
                    op = OP_INSERT;
                else if (pick < 55)
                    op = OP_ERASE;
                else if (pick < 58)
                    op = OP_CLEAR;
                else if (pick < 68)
                    op = OP_PUSH_BACK;
                else if (pick < 78)
                    op = OP_PUSH_FRONT;
                else if (pick < 89)
                    op = OP_POP_BACK;
                else
                    op = OP_POP_FRONT;

                // Mostly legal positions, some anywhere from 0 to CAP
                if ($urandom_range(99) < 15)
                    pos = $urandom_range(CAP);
                else if (op == OP_INSERT)
                    pos = $urandom_range(est_total);
                else if (est_total > 0)
                    pos = $urandom_range(est_total - 1);
                else
                    pos = $urandom_range(CAP);

                // Mostly short inserts, rarely a large one
                pick = $urandom_range(99);
                if (pick < 80)
                    cnt = $urandom_range(4);
                else if (pick < 95)
                    cnt = $urandom_range(16);
                else
                    cnt = $urandom_range(CAP);

                queue_request(op, pos, cnt, $urandom);

                case (op)
                    OP_INSERT: begin
                        if (pos <= est_total && est_total + cnt <= CAP)
                            est_total += cnt;
                    end
                    OP_ERASE: begin
                        if (pos < est_total)
                            est_total--;
                    end
                    OP_CLEAR: est_total = 0;
                    OP_PUSH_BACK, OP_PUSH_FRONT: begin
                        if (est_total < CAP)
                            est_total++;
                    end
                    OP_POP_BACK, OP_POP_FRONT: begin
                        if (est_total > 0)
                            est_total--;
                    end
                    default: ;
                endcase
            end
            drain();
        end

        // Let any stray result show up before the verdict
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (100) @(negedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
